@@ sv/stbg_pkg.sv @@
// ----------------------------------------------------------------------------
// stbg_pkg: shared types, constants and table builders
// Register indexes, sequencer states and the elaboration-time functions
// that fill the sine and envelope tables.
// ----------------------------------------------------------------------------
package stbg_pkg;

  localparam int DefSineDepth   = 1024;
  localparam int DefEnvDepth    = 256;
  localparam int DefSampleWidth = 16;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 32;
  localparam int RomW      = 16;   // signed Q1.15 table word
  localparam int EnvW      = 16;   // envelope value 0..32768
  localparam int MulAW     = 31;
  localparam int MulBW     = 25;
  localparam int ProdW     = 46;

  localparam logic [31:0] ResetPhaseStep = 32'd472446403;
  localparam logic [14:0] ResetAmplitude = 15'd12000;
  localparam logic [15:0] ResetBurstLen  = 16'd2240;
  localparam logic [14:0] ResetRampLen   = 15'd186;
  localparam logic [24:0] ResetRampRecip = 25'd90201;
  localparam logic [15:0] EnvUnity       = 16'd32768;

  localparam logic [63:0] Q30One   = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ENABLE     = 3'd0,
    REG_PHASE_STEP = 3'd1,
    REG_AMPLITUDE  = 3'd2,
    REG_BURST_LEN  = 3'd3,
    REG_RAMP_LEN   = 3'd4,
    REG_RAMP_RECIP = 3'd5
  } reg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_ENV,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } state_e;

  // sin(pi/2 * f) in Q30 for f in Q30 between zero and one.
  function automatic logic [63:0] quarter_sin(input logic [63:0] f);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (f * HalfPiQ30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30One - x2 / 64'd110;
    t  = Q30One - ((x2 * t) >> 30) / 64'd72;
    t  = Q30One - ((x2 * t) >> 30) / 64'd42;
    t  = Q30One - ((x2 * t) >> 30) / 64'd20;
    t  = Q30One - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [14:0] to_q15(input logic [63:0] v);
    logic [63:0] q;
    q = (v + 64'd16384) >> 15;
    return (q > 64'd32767) ? 15'h7FFF : q[14:0];
  endfunction

  function automatic logic signed [RomW-1:0] sine_entry(input int k, input int aw);
    logic [63:0] p;
    logic [63:0] f;
    logic [1:0]  quad;
    logic signed [RomW-1:0] q;
    p    = (64'(k) << 32) >> aw;
    quad = p[31:30];
    f    = p & (Q30One - 64'd1);
    if (quad[0]) begin
      f = Q30One - f;
    end
    q = $signed({1'b0, to_q15(quarter_sin(f))});
    return quad[1] ? -q : q;
  endfunction

  function automatic logic [14:0] env_entry(input int k, input int aw);
    logic [63:0] s;
    s = quarter_sin((64'(k) << 30) >> aw);
    return to_q15((s * s) >> 30);
  endfunction

endpackage

@@ sv/sine_tone_burst_generator.sv @@
// ----------------------------------------------------------------------------
// sine_tone_burst_generator: sine tone bursts with raised-cosine envelope
// One stereo sample per sample tick; triggers start bursts, one request is
// held while a burst plays.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Word
//  s_axis    in         s_axis_tvalid/tready       tdata: trigger
//  m_axis    out        m_axis_tvalid/tready       tdata: left, right; tuser:
//                                                  burst_active; tlast: last
//  cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// A tick is accepted in the idle step and then runs five sequencer steps, so
// the next tick waits for the sequencer to be idle. The shared multiplier is
// used three times (envelope position, sine times envelope, times amplitude);
// the envelope table read adds one step, and the sine read overlaps the first.
// A finished sample waits in the output register while the next tick is
// accepted; the sequencer holds in its last step if that register is full.
// Reset clears all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module sine_tone_burst_generator #(
  parameter int SINE_TABLE_DEPTH     = stbg_pkg::DefSineDepth,
  parameter int ENVELOPE_TABLE_DEPTH = stbg_pkg::DefEnvDepth,
  parameter int SAMPLE_WIDTH         = stbg_pkg::DefSampleWidth
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [7:0]                               s_axis_tdata,  // [0] trigger
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // left_sample, right_sample, zero fill
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  output logic                                     m_axis_tuser,  // [0] burst_active
  output logic                                     m_axis_tlast,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [stbg_pkg::CfgIndexW-1:0]           cfg_index_i,
  input  logic [stbg_pkg::CfgDataW-1:0]            cfg_data_i
);
  import stbg_pkg::*;

  localparam int SineAW    = $clog2(SINE_TABLE_DEPTH);
  localparam int EnvAW     = $clog2(ENVELOPE_TABLE_DEPTH);
  localparam int EnvShift  = 24 - EnvAW;
  localparam int TdataW    = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int ExtW      = SAMPLE_WIDTH + 1;
  localparam int MagW      = (ExtW > 16) ? ExtW : 16;
  localparam logic [ExtW-1:0] SampleLim = ExtW'((1 << (SAMPLE_WIDTH-1)) - 1);

  // Configuration registers.
  logic        enable_q;
  logic [31:0] phase_step_q;
  logic [14:0] amplitude_q;
  logic [15:0] burst_len_q;
  logic [14:0] ramp_len_q;
  logic [24:0] ramp_recip_q;

  // Burst state and per-tick working registers.
  state_e      state_q, state_d;
  logic        playing_q, pending_q, active_q;
  logic [15:0] idx_q;
  logic [31:0] phase_q;
  logic        env_unity_q;
  logic [ProdW-1:0] prod_q;

  logic        out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic        out_active_q, out_last_q;

  // Sequencer controls.
  logic in_take, out_load;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulAW+MulBW-1:0] mul_p;

  logic trigger;
  logic signed [RomW-1:0] sine_rd;
  logic [14:0] env_rd;
  logic [EnvAW-1:0] env_addr;
  logic [40:0] env_full;
  logic [14:0] sine_mag;

  logic        use_attack, use_decay;
  logic [15:0] decay_pos, env_pos;
  logic        last;
  logic [MagW-1:0] mag_ext;
  logic [ExtW-1:0] mag_sat;
  logic signed [ExtW-1:0] sample_ext;

  assign trigger = s_axis_tdata[0];

  stbg_tables #(
    .SINE_TABLE_DEPTH    (SINE_TABLE_DEPTH),
    .ENVELOPE_TABLE_DEPTH(ENVELOPE_TABLE_DEPTH)
  ) u_tables (
    .clk_i      (clk_i),
    .sine_addr_i(phase_q[31 -: SineAW]),
    .env_addr_i (env_addr),
    .sine_data_o(sine_rd),
    .env_data_o (env_rd)
  );

  // Envelope position: attack ramp first, then the trailing decay ramp.
  assign decay_pos  = burst_len_q - idx_q;
  assign use_attack = (ramp_len_q != 15'd0) && (idx_q < {1'b0, ramp_len_q});
  assign use_decay  = (ramp_len_q != 15'd0) && (idx_q < burst_len_q) &&
                      (decay_pos < {1'b0, ramp_len_q});
  assign env_pos    = use_attack ? idx_q : decay_pos;

  assign env_full = prod_q[40:0] >> EnvShift;
  assign env_addr = (|env_full[40:EnvAW]) ? {EnvAW{1'b1}} : env_full[EnvAW-1:0];

  assign sine_mag = sine_rd[RomW-1] ? 15'(-sine_rd) : sine_rd[14:0];
  assign mul_p    = mul_a * mul_b;

  assign last = ({1'b0, idx_q} + 17'd1) >= {1'b0, burst_len_q};

  assign mag_ext    = MagW'(prod_q[45:30]);
  assign mag_sat    = (mag_ext > MagW'(SampleLim)) ? SampleLim : mag_ext[ExtW-1:0];
  assign sample_ext = sine_rd[RomW-1] ? -$signed(mag_sat) : $signed(mag_sat);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_INDEX;
      ST_INDEX: state_d = ST_ENV;
      ST_ENV:   state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and multiplier operand select.
  always_comb begin
    in_take  = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      ST_IDLE: in_take = s_axis_tvalid;
      ST_INDEX: begin
        mul_a = MulAW'(env_pos);
        mul_b = ramp_recip_q;
      end
      // The envelope table word read during the envelope step is valid here.
      ST_MUL1: begin
        mul_a = MulAW'(sine_mag);
        mul_b = env_unity_q ? MulBW'(EnvUnity) : MulBW'(env_rd);
      end
      ST_MUL2: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = MulBW'(amplitude_q);
      end
      ST_OUT:  out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      phase_step_q <= ResetPhaseStep;
      amplitude_q  <= ResetAmplitude;
      burst_len_q  <= ResetBurstLen;
      ramp_len_q   <= ResetRampLen;
      ramp_recip_q <= ResetRampRecip;
    end else if (cfg_valid_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_ENABLE:     enable_q     <= cfg_data_i[0];
        REG_PHASE_STEP: phase_step_q <= cfg_data_i;
        REG_AMPLITUDE:  amplitude_q  <= cfg_data_i[14:0];
        REG_BURST_LEN:  burst_len_q  <= cfg_data_i[15:0];
        REG_RAMP_LEN:   ramp_len_q   <= cfg_data_i[14:0];
        REG_RAMP_RECIP: ramp_recip_q <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      playing_q   <= 1'b0;
      pending_q   <= 1'b0;
      active_q    <= 1'b0;
      idx_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        if (!enable_q) begin
          playing_q <= 1'b0;
          pending_q <= 1'b0;
          active_q  <= 1'b0;
          idx_q     <= '0;
          phase_q   <= '0;
        end else if (trigger && playing_q) begin
          pending_q <= 1'b1;
          active_q  <= 1'b1;
        end else if (trigger) begin
          playing_q <= 1'b1;
          active_q  <= 1'b1;
          idx_q     <= '0;
          phase_q   <= '0;
        end else begin
          active_q  <= playing_q;
        end
      end
      if (out_load && active_q) begin
        if (last) begin
          idx_q   <= '0;
          phase_q <= '0;
          if (pending_q) begin
            pending_q <= 1'b0;
          end else begin
            playing_q <= 1'b0;
          end
        end else begin
          idx_q   <= idx_q + 16'd1;
          phase_q <= phase_q + phase_step_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_INDEX: begin
        env_unity_q <= !(use_attack || use_decay);
        prod_q      <= ProdW'(mul_p);
      end
      ST_MUL1: prod_q <= ProdW'(mul_p);
      ST_MUL2: prod_q <= ProdW'(mul_p);
      default: ;
    endcase
    if (out_load) begin
      out_sample_q <= active_q ? sample_ext[SAMPLE_WIDTH-1:0] : '0;
      out_active_q <= active_q;
      out_last_q   <= active_q && last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataW'({out_sample_q, out_sample_q});
  assign m_axis_tuser  = out_active_q;
  assign m_axis_tlast  = out_last_q;

  // A new sample appears only from the final sequencer step.
  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output valid rose outside the output step");

  // A last sample always belongs to a burst.
  a_last_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_active_q)
    else $error("burst_last without burst_active");

  // Samples outside a burst are silent.
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_active_q |-> out_sample_q == '0)
    else $error("idle sample is not zero");

  // The index restarts after the final sample of a burst.
  a_index_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && active_q && last |=> idx_q == '0 && phase_q == '0)
    else $error("index or phase not cleared after burst end");

endmodule

@@ sv/stbg_tables.sv @@
// ----------------------------------------------------------------------------
// stbg_tables: sine and envelope lookup tables
// Constant tables built at elaboration, each read through an output register.
// ----------------------------------------------------------------------------
module stbg_tables #(
  parameter int SINE_TABLE_DEPTH     = stbg_pkg::DefSineDepth,
  parameter int ENVELOPE_TABLE_DEPTH = stbg_pkg::DefEnvDepth
) (
  input  logic                                    clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]     sine_addr_i,
  input  logic [$clog2(ENVELOPE_TABLE_DEPTH)-1:0] env_addr_i,
  output logic signed [stbg_pkg::RomW-1:0]        sine_data_o,
  output logic [14:0]                             env_data_o
);
  import stbg_pkg::*;

  localparam int SineAW = $clog2(SINE_TABLE_DEPTH);
  localparam int EnvAW  = $clog2(ENVELOPE_TABLE_DEPTH);

  logic signed [RomW-1:0] sine_rom [SINE_TABLE_DEPTH];
  logic [14:0]            env_rom  [ENVELOPE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam logic signed [RomW-1:0] Val = sine_entry(k, SineAW);
    assign sine_rom[k] = Val;
  end

  for (genvar k = 0; k < ENVELOPE_TABLE_DEPTH; k++) begin : g_env
    localparam logic [14:0] Val = env_entry(k, EnvAW);
    assign env_rom[k] = Val;
  end

  always_ff @(posedge clk_i) begin
    sine_data_o <= sine_rom[sine_addr_i];
    env_data_o  <= env_rom[env_addr_i];
  end

endmodule
